@@ src/emrs_pkg.sv @@
// ----------------------------------------------------------------------------
// emrs_pkg
// Shared types and constants for the e-paper refresh mode selector.
// ----------------------------------------------------------------------------
package emrs_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int NOW_W              = 32;
  localparam int RECT_W             = 16;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;

  // command codes
  localparam logic [1:0] CMD_CTRL   = 2'd0;
  localparam logic [1:0] CMD_PEN    = 2'd1;
  localparam logic [1:0] CMD_ITEM   = 2'd2;
  localparam logic [1:0] CMD_REGION = 2'd3;

  // signal numbers
  localparam logic [3:0] SIG_ROUTE    = 4'd0;
  localparam logic [3:0] SIG_PAGE     = 4'd12;
  localparam logic [3:0] SIG_PEN_DOWN = 4'd4;
  localparam logic [3:0] SIG_PEN_MOVE = 4'd5;
  localparam logic [3:0] SIG_PEN_UP   = 4'd6;

  // refresh modes
  localparam logic [2:0] MODE_PEN     = 3'd0;
  localparam logic [2:0] MODE_CONTENT = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_TAIL      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUP_WINDOW    = 2'd3;

  // register reset values
  localparam logic [2:0]  BASE_MODE_RST     = 3'd1;
  localparam logic [7:0]  PAGE_INTERVAL_RST = 8'd0;
  localparam logic [15:0] PEN_TAIL_RST      = 16'd50;
  localparam logic [15:0] DUP_WINDOW_RST    = 16'd400;

  typedef struct packed {
    logic [2:0]  base_mode;
    logic [7:0]  page_interval;
    logic [15:0] pen_tail_ms;
    logic [15:0] dup_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [NOW_W-1:0]         now_ms;
    logic [3:0]               signal_index;
    logic [2:0]               requested_mode;
    logic signed [RECT_W-1:0] rect_left;
    logic signed [RECT_W-1:0] rect_top;
    logic signed [RECT_W-1:0] rect_right;
    logic signed [RECT_W-1:0] rect_bottom;
  } item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
  } res_t;

endpackage

@@ src/emrs_cfg.sv @@
// ----------------------------------------------------------------------------
// emrs_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module emrs_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [emrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emrs_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output emrs_pkg::cfg_t                  cfg
);
  import emrs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_mode     <= BASE_MODE_RST;
      cfg.page_interval <= PAGE_INTERVAL_RST;
      cfg.pen_tail_ms   <= PEN_TAIL_RST;
      cfg.dup_window_ms <= DUP_WINDOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BASE_MODE:     cfg.base_mode     <= cfg_wr_data[2:0];
        REG_PAGE_INTERVAL: cfg.page_interval <= cfg_wr_data[7:0];
        REG_PEN_TAIL:      cfg.pen_tail_ms   <= cfg_wr_data;
        REG_DUP_WINDOW:    cfg.dup_window_ms <= cfg_wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/emrs_core.sv @@
// ----------------------------------------------------------------------------
// emrs_core
// Page and pen state with the mode decision for the word in the input stage.
// ----------------------------------------------------------------------------
module emrs_core #(
  parameter int TIME_WIDTH = emrs_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  emrs_pkg::item_t item,
  input  emrs_pkg::cfg_t  cfg,
  output emrs_pkg::res_t  res
);
  import emrs_pkg::*;

  localparam int TW = (TIME_WIDTH < NOW_W) ? TIME_WIDTH : NOW_W;
  localparam int DW = TW + 1;

  logic [DW-1:0]     pen_deadline, pen_deadline_next;
  logic              turn_pending, turn_pending_next;
  logic              seen_first, seen_first_next;
  logic              screen_known, screen_known_next;
  logic [RECT_W-1:0] screen_right, screen_right_next;
  logic [RECT_W-1:0] screen_bottom, screen_bottom_next;
  logic [7:0]        turn_count, turn_count_next;
  logic [TW-1:0]     last_time, last_time_next;

  logic [TW-1:0] now;
  logic [DW-1:0] pen_sum;
  logic [TW-1:0] age;
  logic [7:0]    cnt_inc;
  logic          pen_active, pen_sig, full_rect, dims_ok, dup, keep;

  always_comb begin
    now        = item.now_ms[TW-1:0];
    pen_sum    = {1'b0, now} + DW'(cfg.pen_tail_ms);
    pen_active = (now != '0) && ({1'b0, now} < pen_deadline);
    pen_sig    = (item.signal_index == SIG_PEN_DOWN) || (item.signal_index == SIG_PEN_MOVE) ||
                 (item.signal_index == SIG_PEN_UP);
    full_rect  = (item.rect_left == '0) && (item.rect_top == '0) &&
                 !item.rect_right[RECT_W-1] && !item.rect_bottom[RECT_W-1];
    dims_ok    = !screen_known || ((screen_right == item.rect_right) &&
                                   (screen_bottom == item.rect_bottom));
    age        = now - last_time;
    dup        = (last_time != '0) && (now >= last_time) && (age <= TW'(cfg.dup_window_ms));
    cnt_inc    = turn_count + 8'd1;
    keep       = 1'b0;

    pen_deadline_next  = pen_deadline;
    turn_pending_next  = turn_pending;
    seen_first_next    = seen_first;
    screen_known_next  = screen_known;
    screen_right_next  = screen_right;
    screen_bottom_next = screen_bottom;
    turn_count_next    = turn_count;
    last_time_next     = last_time;
    res.mode           = (item.requested_mode == MODE_PEN) ? MODE_PEN : cfg.base_mode;
    res.full           = 1'b0;

    unique case (item.cmd)
      CMD_CTRL: begin
        if (item.signal_index == SIG_ROUTE) begin
          turn_pending_next  = 1'b0;
          seen_first_next    = 1'b0;
          screen_known_next  = 1'b0;
          screen_right_next  = '0;
          screen_bottom_next = '0;
          turn_count_next    = '0;
          last_time_next     = '0;
        end else if (item.signal_index == SIG_PAGE) begin
          turn_pending_next = 1'b1;
        end
      end
      CMD_PEN: begin
        if (pen_sig && (now != '0) && (pen_deadline < pen_sum)) begin
          pen_deadline_next = pen_sum;
        end
      end
      CMD_ITEM: begin
        if (pen_active) begin
          res.mode = MODE_PEN;
        end
      end
      CMD_REGION: begin
        if ((item.requested_mode == MODE_CONTENT) && full_rect && turn_pending && dims_ok) begin
          screen_known_next  = 1'b1;
          screen_right_next  = item.rect_right;
          screen_bottom_next = item.rect_bottom;
          turn_pending_next  = 1'b0;
          if (!seen_first) begin
            seen_first_next = 1'b1;
            last_time_next  = now;
          end else if (!dup) begin
            last_time_next = now;
            if (cfg.page_interval != '0) begin
              if (cnt_inc < cfg.page_interval) begin
                turn_count_next = cnt_inc;
              end else begin
                turn_count_next = '0;
                keep            = 1'b1;
              end
            end
          end
        end
        if (pen_active) begin
          res.mode = MODE_PEN;
        end else if (keep) begin
          res.mode = MODE_CONTENT;
          res.full = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_deadline  <= '0;
      turn_pending  <= 1'b0;
      seen_first    <= 1'b0;
      screen_known  <= 1'b0;
      screen_right  <= '0;
      screen_bottom <= '0;
      turn_count    <= '0;
      last_time     <= '0;
    end else if (fire) begin
      pen_deadline  <= pen_deadline_next;
      turn_pending  <= turn_pending_next;
      seen_first    <= seen_first_next;
      screen_known  <= screen_known_next;
      screen_right  <= screen_right_next;
      screen_bottom <= screen_bottom_next;
      turn_count    <= turn_count_next;
      last_time     <= last_time_next;
    end
  end

  a_deadline_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> pen_deadline >= $past(pen_deadline))
    else $error("pen deadline moved backwards");

  a_keep_needs_first: assert property (@(posedge clk) disable iff (rst)
    (fire && keep) |-> (seen_first && screen_known))
    else $error("full refresh kept without a first candidate");

endmodule

@@ src/emrs_out_reg.sv @@
// ----------------------------------------------------------------------------
// emrs_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module emrs_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  emrs_pkg::res_t res,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [2:0]     effective_mode,
  output logic           full_refresh
);
  import emrs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      effective_mode <= res.mode;
      full_refresh   <= res.full;
    end
  end

endmodule

@@ src/eink_refresh_mode_selector.sv @@
// ----------------------------------------------------------------------------
// eink_refresh_mode_selector
// Picks the e-paper refresh mode from a stream of timestamped events.
//
// Input words (in_valid/in_ready) carry controller signals, pen signals and
// item or region mode requests. Signals update page and pen state and give
// no output; each request gives one output word (out_valid/out_ready) with
// effective_mode and full_refresh.
// A word is captured in an input register and decided from there; the edge
// on which it fires applies it to the state and loads a request's result
// into the output register.
// One word per cycle is sustained unless a request waits on a held result;
// the state update is a single compare-and-add step.
// When the receiver stalls with a result held, the input stage keeps taking
// signal words and holds a request until the output register frees, so
// in_ready drops only then. in_ready is low during reset. Reset clears the
// page and pen state and the valid flags and restores the register defaults;
// configuration is written through cfg_wr_en/cfg_index/cfg_wr_data.
// ----------------------------------------------------------------------------
module eink_refresh_mode_selector #(
  parameter int TIME_WIDTH = emrs_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [emrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emrs_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [emrs_pkg::NOW_W-1:0]      now_ms,
  input  logic [3:0]                      signal_index,
  input  logic [2:0]                      requested_mode,
  input  logic signed [15:0]              rect_left,
  input  logic signed [15:0]              rect_top,
  input  logic signed [15:0]              rect_right,
  input  logic signed [15:0]              rect_bottom,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      effective_mode,
  output logic                            full_refresh
);
  import emrs_pkg::*;

  cfg_t  cfg;
  item_t s1_item;
  res_t  res;
  logic  s1_valid, s1_is_req, s1_fire, out_load;

  assign s1_is_req = (s1_item.cmd == CMD_ITEM) || (s1_item.cmd == CMD_REGION);
  assign s1_fire   = s1_valid && (!s1_is_req || !out_valid || out_ready);
  assign out_load  = s1_fire && s1_is_req;
  assign in_ready  = !rst && (!s1_valid || s1_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.cmd            <= cmd;
      s1_item.now_ms         <= now_ms;
      s1_item.signal_index   <= signal_index;
      s1_item.requested_mode <= requested_mode;
      s1_item.rect_left      <= rect_left;
      s1_item.rect_top       <= rect_top;
      s1_item.rect_right     <= rect_right;
      s1_item.rect_bottom    <= rect_bottom;
    end
  end

  emrs_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  emrs_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  emrs_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (out_load),
    .res            (res),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .effective_mode (effective_mode),
    .full_refresh   (full_refresh)
  );

  a_full_is_content: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_refresh) |-> (effective_mode == MODE_CONTENT))
    else $error("full refresh without content mode");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word lost from input stage");

  a_signal_no_result: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_is_req && out_valid && out_ready) |=> !out_valid)
    else $error("signal word produced a result");

endmodule
